/* hw/rtl/vtx_pkg.sv */
// ----------------------------------------------------------------------------
// vtx_pkg
// Shared widths, reset values, register indexes and pipeline enable type of
// the 4x4 vertex transform.
// ----------------------------------------------------------------------------
package vtx_pkg;

  localparam int unsigned LANES    = 4;
  localparam int unsigned COMP_W   = 32;   // Q16.16 component
  localparam int unsigned ENTRY_W  = 16;   // Q4.12 matrix entry
  localparam int unsigned ROW_W    = LANES * ENTRY_W;
  localparam int unsigned FRAC_SH  = 12;   // Q20.28 -> Q20.16
  localparam int unsigned PROD_W   = ENTRY_W + COMP_W;        // 48
  localparam int unsigned RND_W    = PROD_W - FRAC_SH;        // 36
  localparam int unsigned PAIR_W   = RND_W + 1;               // 37
  localparam int unsigned SUM_W    = PAIR_W + 1;              // 38
  localparam int unsigned VEC_W    = LANES * COMP_W;          // 128
  localparam int unsigned IDX_W    = 8;

  localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(2048);

  // Identity matrix, 1.0 = 4096 on the diagonal
  localparam logic [ROW_W-1:0] ROW_0_RST = 64'h0000_0000_0000_1000;
  localparam logic [ROW_W-1:0] ROW_1_RST = 64'h0000_0000_1000_0000;
  localparam logic [ROW_W-1:0] ROW_2_RST = 64'h0000_1000_0000_0000;
  localparam logic [ROW_W-1:0] ROW_3_RST = 64'h1000_0000_0000_0000;

  localparam logic [IDX_W-1:0] REG_ROW_0 = 8'd0;
  localparam logic [IDX_W-1:0] REG_ROW_1 = 8'd1;
  localparam logic [IDX_W-1:0] REG_ROW_2 = 8'd2;
  localparam logic [IDX_W-1:0] REG_ROW_3 = 8'd3;

  // Per-stage load enables handed to every lane
  typedef struct packed {
    logic mul;
    logic pair;
    logic sum;
  } lane_en_t;

endpackage

/* hw/rtl/vertex_transform_4x4.sv */
// ----------------------------------------------------------------------------
// vertex_transform_4x4
// 4x4 fixed-point matrix times 4-component vector, streaming.
// ----------------------------------------------------------------------------
// Each word on the slave side is one vector (x, y, z, w in signed Q16.16);
// each word on the master side is the matrix times that vector, one result
// component per matrix row, clamped to signed 32 bits, with tuser set when any
// component clamped. The matrix is four row registers of four signed Q4.12
// entries (column 0 in the low 16 bits), written through the cfg port and
// reset to identity; indexes above three are dropped. Every product is
// rounded to Q20.16 (nearest, ties toward plus infinity) before the row sum.
// For points, send w = 1.0 (0x00010000) and ignore out_w. The block takes one
// vector per clock while the master side is ready; inside the block, four
// row lanes of four multipliers each run side by side through a multiply
// stage, a round-and-pair-add stage and a final add with clamp, then the
// merged word lands in the output register. Each stage holds its word only
// while the stage after it is full and stalled, so a full pipe keeps taking
// vectors while the master side is ready. Write the matrix only while the
// pipe is empty.
// ----------------------------------------------------------------------------
module vertex_transform_4x4
  import vtx_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  // slave side
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [VEC_W-1:0]   s_tdata,    // in_x[31:0], in_y[63:32], in_z[95:64], in_w[127:96]
  // master side
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [VEC_W-1:0]   m_tdata,    // out_x[31:0], out_y[63:32], out_z[95:64], out_w[127:96]
  output logic [0:0]         m_tuser,    // saturated[0]
  // matrix writes
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [IDX_W-1:0]   cfg_index,
  input  logic [ROW_W-1:0]   cfg_data
);

  logic [LANES-1:0][ROW_W-1:0]   rows;
  logic [LANES-1:0][COMP_W-1:0]  vec;
  logic [LANES-1:0][COMP_W-1:0]  lane_result;
  logic [LANES-1:0]              lane_sat;
  lane_en_t                      en;
  logic                          v_mul;
  logic                          v_pair;
  logic                          v_sum;
  logic                          merge_free;
  logic                          rdy_sum;
  logic                          rdy_pair;
  logic                          rdy_mul;

  // Matrix registers: always ready, out-of-range index is a no-op
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows[0] <= ROW_0_RST;
      rows[1] <= ROW_1_RST;
      rows[2] <= ROW_2_RST;
      rows[3] <= ROW_3_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ROW_0: rows[0] <= cfg_data;
        REG_ROW_1: rows[1] <= cfg_data;
        REG_ROW_2: rows[2] <= cfg_data;
        REG_ROW_3: rows[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  assign vec = s_tdata;

  // Backpressure: a stage advances when it is empty or the next one moves
  assign rdy_sum  = !v_sum  || merge_free;
  assign rdy_pair = !v_pair || rdy_sum;
  assign rdy_mul  = !v_mul  || rdy_pair;
  assign s_tready = rdy_mul;

  assign en.mul  = rdy_mul;
  assign en.pair = rdy_pair;
  assign en.sum  = rdy_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_mul  <= 1'b0;
      v_pair <= 1'b0;
      v_sum  <= 1'b0;
    end else begin
      if (rdy_mul) begin
        v_mul <= s_tvalid;
      end
      if (rdy_pair) begin
        v_pair <= v_mul;
      end
      if (rdy_sum) begin
        v_sum <= v_pair;
      end
    end
  end

  // One lane per matrix row
  for (genvar r = 0; r < LANES; r++) begin : g_lane
    vtx_lane u_lane (
      .clk    (clk),
      .en     (en),
      .row    (rows[r]),
      .vec    (vec),
      .result (lane_result[r]),
      .sat    (lane_sat[r])
    );
  end

  vtx_merge u_merge (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (v_sum),
    .lane_result (lane_result),
    .lane_sat    (lane_sat),
    .free        (merge_free),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser)
  );

endmodule

/* hw/rtl/vtx_lane.sv */
// ----------------------------------------------------------------------------
// vtx_lane
// One matrix row times the vector: multiply, round and pair-add, final add
// with saturation. Three register stages.
// ----------------------------------------------------------------------------
module vtx_lane
  import vtx_pkg::*;
(
  input  logic                          clk,
  input  lane_en_t                      en,
  input  logic [ROW_W-1:0]              row,
  input  logic [LANES-1:0][COMP_W-1:0]  vec,
  output logic [COMP_W-1:0]             result,
  output logic                          sat
);

  logic signed [PROD_W-1:0] prod [LANES];
  logic signed [PROD_W-1:0] rnd_full [LANES];
  logic signed [RND_W-1:0]  rnd [LANES];
  logic signed [PAIR_W-1:0] pair [2];
  logic signed [SUM_W-1:0]  sum_next;
  logic [COMP_W-1:0]        clamp;
  logic                     clamp_sat;

  // Stage 1: four products Q4.12 x Q16.16
  always_ff @(posedge clk) begin
    if (en.mul) begin
      for (int c = 0; c < LANES; c++) begin
        prod[c] <= $signed(row[c*ENTRY_W +: ENTRY_W]) * $signed(vec[c]);
      end
    end
  end

  // Round to nearest, ties up: floor((p + half) / 4096)
  always_comb begin
    for (int c = 0; c < LANES; c++) begin
      rnd_full[c] = prod[c] + ROUND_HALF;
      rnd[c]      = rnd_full[c][PROD_W-1:FRAC_SH];
    end
  end

  // Stage 2: pairwise sums
  always_ff @(posedge clk) begin
    if (en.pair) begin
      pair[0] <= PAIR_W'(rnd[0]) + PAIR_W'(rnd[1]);
      pair[1] <= PAIR_W'(rnd[2]) + PAIR_W'(rnd[3]);
    end
  end

  // Final sum and clamp to signed 32 bits
  always_comb begin
    sum_next  = SUM_W'(pair[0]) + SUM_W'(pair[1]);
    clamp_sat = (sum_next[SUM_W-1:COMP_W-1] != '0) && (sum_next[SUM_W-1:COMP_W-1] != '1);
    if (!clamp_sat) begin
      clamp = sum_next[COMP_W-1:0];
    end else if (sum_next[SUM_W-1]) begin
      clamp = {1'b1, {(COMP_W-1){1'b0}}};
    end else begin
      clamp = {1'b0, {(COMP_W-1){1'b1}}};
    end
  end

  // Stage 3
  always_ff @(posedge clk) begin
    if (en.sum) begin
      result <= clamp;
      sat    <= clamp_sat;
    end
  end

endmodule

/* hw/rtl/vtx_merge.sv */
// ----------------------------------------------------------------------------
// vtx_merge
// Collect the four lane results into one output word, fold the lane
// saturation flags, and hold the word until the master side takes it.
// ----------------------------------------------------------------------------
module vtx_merge
  import vtx_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic [LANES-1:0][COMP_W-1:0]  lane_result,
  input  logic [LANES-1:0]              lane_sat,
  output logic                          free,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [VEC_W-1:0]              m_tdata,
  output logic [0:0]                    m_tuser
);

  assign free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (free) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (free) begin
      m_tdata    <= lane_result;
      m_tuser[0] <= |lane_sat;
    end
  end

endmodule
